FILE: rtl/core/sfpt_pkg.sv
// ----------------------------------------------------------------------------
// sfpt_pkg: shared definitions for the shortest-path frontier table
// Operation codes, controller states, per-cell command struct and defaults.
// ----------------------------------------------------------------------------
package sfpt_pkg;

	// default sizes
	localparam int ENTRIES_DEF   = 64;
	localparam int NODE_BITS_DEF = 16;
	localparam int DIST_BITS_DEF = 32;

	// operation codes carried in s_tuser; the spare code acts as a query
	localparam logic [1:0] OP_QUERY  = 2'd0;
	localparam logic [1:0] OP_UPSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD,
		ST_SCAN,
		ST_DONE
	} state_t;

	// command to one cell for the update cycle
	typedef struct packed {
		logic load;   // overwrite predecessor and distance in place
		logic push;   // take the front neighbor's slot (insert at head)
		logic pull;   // take the back neighbor's slot (close a gap)
	} cell_cmd_t;

endpackage

FILE: rtl/core/sfpt_prefix.sv
// ----------------------------------------------------------------------------
// sfpt_prefix: inclusive prefix OR over the per-cell match bits
// Log-depth parallel prefix; bit i is set when any match at index <= i.
// ----------------------------------------------------------------------------
module sfpt_prefix #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0] bits,
	output logic [WIDTH-1:0] incl
);

	localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] lvl [LEVELS+1];

	assign lvl[0] = bits;

	// one doubling step per level
	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		for (genvar i = 0; i < WIDTH; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
			end else begin : g_keep
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign incl = lvl[LEVELS];

endmodule

FILE: rtl/core/sfpt_cell.sv
// ----------------------------------------------------------------------------
// sfpt_cell: one slot of the frontier table
// Holds node, predecessor and distance, shifts with its neighbors on insert
// and remove, and folds its slot into the lookup and minimum record that
// travels toward the head of the chain one cell per cycle.
// ----------------------------------------------------------------------------
module sfpt_cell #(
	parameter int NODE_BITS = 16,
	parameter int DIST_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sfpt_pkg::cell_cmd_t   cmd,
	// item under work
	input  logic [NODE_BITS-1:0]  item_node,
	input  logic [NODE_BITS-1:0]  item_pred,
	input  logic [DIST_BITS-1:0]  item_dist,
	// front neighbor slot (newer side)
	input  logic                  front_valid,
	input  logic [NODE_BITS-1:0]  front_node,
	input  logic [NODE_BITS-1:0]  front_pred,
	input  logic [DIST_BITS-1:0]  front_dist,
	// back neighbor slot (older side)
	input  logic                  back_valid,
	input  logic [NODE_BITS-1:0]  back_node,
	input  logic [NODE_BITS-1:0]  back_pred,
	input  logic [DIST_BITS-1:0]  back_dist,
	// record from the back neighbor
	input  logic                  chain_found,
	input  logic [DIST_BITS-1:0]  chain_fdist,
	input  logic [NODE_BITS-1:0]  chain_fpred,
	input  logic                  chain_edge,
	input  logic                  chain_bvalid,
	input  logic [DIST_BITS-1:0]  chain_bdist,
	input  logic [NODE_BITS-1:0]  chain_bnode,
	// own slot
	output logic                  slot_valid,
	output logic [NODE_BITS-1:0]  slot_node,
	output logic [NODE_BITS-1:0]  slot_pred,
	output logic [DIST_BITS-1:0]  slot_dist,
	output logic                  eq,
	// record toward the front neighbor
	output logic                  rec_found,
	output logic [DIST_BITS-1:0]  rec_fdist,
	output logic [NODE_BITS-1:0]  rec_fpred,
	output logic                  rec_edge,
	output logic                  rec_bvalid,
	output logic [DIST_BITS-1:0]  rec_bdist,
	output logic [NODE_BITS-1:0]  rec_bnode
);

	import sfpt_pkg::*;

	logic                 valid_q;
	logic [NODE_BITS-1:0] node_q;
	logic [NODE_BITS-1:0] pred_q;
	logic [DIST_BITS-1:0] dist_q;

	logic                 found_q, edge_q, bvalid_q;
	logic [DIST_BITS-1:0] fdist_q, bdist_q;
	logic [NODE_BITS-1:0] fpred_q, bnode_q;

	logic                 found_d, edge_d, bvalid_d;
	logic [DIST_BITS-1:0] fdist_d, bdist_d;
	logic [NODE_BITS-1:0] fpred_d, bnode_d;

	// slot valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push) begin
			valid_q <= front_valid;
		end else if (cmd.pull) begin
			valid_q <= back_valid;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			node_q <= front_node;
			pred_q <= front_pred;
			dist_q <= front_dist;
		end else if (cmd.pull) begin
			node_q <= back_node;
			pred_q <= back_pred;
			dist_q <= back_dist;
		end else if (cmd.load) begin
			pred_q <= item_pred;
			dist_q <= item_dist;
		end
	end

	assign eq = valid_q && (node_q == item_node);

	// fold own slot into the record from behind; ties go to the newer slot
	always_comb begin
		found_d  = 1'b0;
		fdist_d  = '1;
		fpred_d  = '1;
		edge_d   = 1'b0;
		bvalid_d = 1'b0;
		bdist_d  = '1;
		bnode_d  = '1;
		if (valid_q) begin
			found_d = eq | chain_found;
			fdist_d = eq ? dist_q : chain_fdist;
			fpred_d = eq ? pred_q : chain_fpred;
			edge_d  = (eq && (pred_q == item_pred)) | chain_edge;
			if (!chain_bvalid || (dist_q <= chain_bdist)) begin
				bvalid_d = 1'b1;
				bdist_d  = dist_q;
				bnode_d  = node_q;
			end else begin
				bvalid_d = chain_bvalid;
				bdist_d  = chain_bdist;
				bnode_d  = chain_bnode;
			end
		end
	end

	// record register, flags reset to the empty record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			edge_q   <= 1'b0;
			bvalid_q <= 1'b0;
		end else begin
			found_q  <= found_d;
			edge_q   <= edge_d;
			bvalid_q <= bvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		fdist_q <= fdist_d;
		fpred_q <= fpred_d;
		bdist_q <= bdist_d;
		bnode_q <= bnode_d;
	end

	assign slot_valid = valid_q;
	assign slot_node  = node_q;
	assign slot_pred  = pred_q;
	assign slot_dist  = dist_q;
	assign rec_found  = found_q;
	assign rec_fdist  = fdist_q;
	assign rec_fpred  = fpred_q;
	assign rec_edge   = edge_q;
	assign rec_bvalid = bvalid_q;
	assign rec_bdist  = bdist_q;
	assign rec_bnode  = bnode_q;

endmodule

FILE: rtl/core/shortest_path_frontier_table_unit.sv
// ----------------------------------------------------------------------------
// shortest_path_frontier_table_unit: open-set table for a shortest-path search
// Chain of slot cells ordered newest first, with upsert, remove and query.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the s_ stream: s_tuser is the operation (query, upsert,
// remove), s_tdata holds node, predecessor and distance. Every accepted
// transaction gives one result transaction on the m_ stream with the node's
// lookup, the edge flag, the table minimum, the empty flag and the drop flag.
// One command is in work at a time. After acceptance the command passes the
// compare, update and scan states; the scan lasts while the lookup and minimum
// record walks from the oldest valid slot to the head, one cell per cycle. In
// the done state the result is loaded into the output register and the block
// returns to idle, where the next command is taken.
// The result sits in an output register: a new command is taken while it
// waits, and a finished result waits in the done state until the register is
// free. A stall on m_tready stops the block only there.
// Reset empties the table at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
module shortest_path_frontier_table_unit #(
	parameter int ENTRIES   = sfpt_pkg::ENTRIES_DEF,
	parameter int NODE_BITS = sfpt_pkg::NODE_BITS_DEF,
	parameter int DIST_BITS = sfpt_pkg::DIST_BITS_DEF,
	localparam int IN_W     = 2 * NODE_BITS + DIST_BITS,
	localparam int IN_PW    = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W    = 2 * NODE_BITS + DIST_BITS + 4,
	localparam int OUT_PW   = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// node, predecessor, distance
	input  logic [IN_PW-1:0]  s_tdata,
	// operation
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// node_found, node_distance, node_predecessor, edge_found, min_node,
	// table_empty, insert_dropped
	output logic [OUT_PW-1:0] m_tdata
);

	import sfpt_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	state_t state_q, state_d;

	logic [1:0]           op_q;
	logic [NODE_BITS-1:0] node_q, pred_q;
	logic [DIST_BITS-1:0] dist_q;
	logic [ENTRIES-1:0]   match_q;
	logic [CW-1:0]        count_q, count_d, scan_q;
	logic                 dropped_q;
	logic                 out_valid_q;
	logic [OUT_PW-1:0]    out_data_q;

	logic accept, load_out, any, full, do_push, do_remove;
	logic [ENTRIES-1:0] incl;

	// per-cell wiring; index ENTRIES is the empty tail
	logic [ENTRIES-1:0]   eqv;
	logic [ENTRIES:0]     c_valid;
	logic [NODE_BITS-1:0] c_node [ENTRIES+1];
	logic [NODE_BITS-1:0] c_pred [ENTRIES+1];
	logic [DIST_BITS-1:0] c_dist [ENTRIES+1];
	logic [ENTRIES:0]     r_found, r_edge, r_bvalid;
	logic [DIST_BITS-1:0] r_fdist [ENTRIES+1];
	logic [NODE_BITS-1:0] r_fpred [ENTRIES+1];
	logic [DIST_BITS-1:0] r_bdist [ENTRIES+1];
	logic [NODE_BITS-1:0] r_bnode [ENTRIES+1];
	cell_cmd_t            cmd [ENTRIES];

	assign accept   = s_tvalid && s_tready;
	assign any      = incl[ENTRIES-1];
	assign full     = c_valid[ENTRIES-1];
	assign do_push  = (state_q == ST_UPD) && (op_q == OP_UPSERT) && !any && !full;
	assign do_remove = (state_q == ST_UPD) && (op_q == OP_REMOVE) && any;

	// empty tail of the chain
	assign c_valid[ENTRIES]  = 1'b0;
	assign c_node[ENTRIES]   = '0;
	assign c_pred[ENTRIES]   = '0;
	assign c_dist[ENTRIES]   = '0;
	assign r_found[ENTRIES]  = 1'b0;
	assign r_edge[ENTRIES]   = 1'b0;
	assign r_bvalid[ENTRIES] = 1'b0;
	assign r_fdist[ENTRIES]  = '1;
	assign r_fpred[ENTRIES]  = '1;
	assign r_bdist[ENTRIES]  = '1;
	assign r_bnode[ENTRIES]  = '1;

	// prefix of matches selects a removed slot and the cells behind it
	sfpt_prefix #(
		.WIDTH (ENTRIES)
	) u_prefix (
		.bits (match_q),
		.incl (incl)
	);

	// row of slot cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic                 f_valid;
		logic [NODE_BITS-1:0] f_node, f_pred;
		logic [DIST_BITS-1:0] f_dist;

		if (i == 0) begin : g_head
			assign f_valid = 1'b1;
			assign f_node  = node_q;
			assign f_pred  = pred_q;
			assign f_dist  = dist_q;
		end else begin : g_body
			assign f_valid = c_valid[i-1];
			assign f_node  = c_node[i-1];
			assign f_pred  = c_pred[i-1];
			assign f_dist  = c_dist[i-1];
		end

		assign cmd[i].load = (state_q == ST_UPD) && (op_q == OP_UPSERT) && match_q[i];
		assign cmd[i].push = do_push;
		assign cmd[i].pull = do_remove && incl[i];

		sfpt_cell #(
			.NODE_BITS (NODE_BITS),
			.DIST_BITS (DIST_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd[i]),
			.item_node    (node_q),
			.item_pred    (pred_q),
			.item_dist    (dist_q),
			.front_valid  (f_valid),
			.front_node   (f_node),
			.front_pred   (f_pred),
			.front_dist   (f_dist),
			.back_valid   (c_valid[i+1]),
			.back_node    (c_node[i+1]),
			.back_pred    (c_pred[i+1]),
			.back_dist    (c_dist[i+1]),
			.chain_found  (r_found[i+1]),
			.chain_fdist  (r_fdist[i+1]),
			.chain_fpred  (r_fpred[i+1]),
			.chain_edge   (r_edge[i+1]),
			.chain_bvalid (r_bvalid[i+1]),
			.chain_bdist  (r_bdist[i+1]),
			.chain_bnode  (r_bnode[i+1]),
			.slot_valid   (c_valid[i]),
			.slot_node    (c_node[i]),
			.slot_pred    (c_pred[i]),
			.slot_dist    (c_dist[i]),
			.eq           (eqv[i]),
			.rec_found    (r_found[i]),
			.rec_fdist    (r_fdist[i]),
			.rec_fpred    (r_fpred[i]),
			.rec_edge     (r_edge[i]),
			.rec_bvalid   (r_bvalid[i]),
			.rec_bdist    (r_bdist[i]),
			.rec_bnode    (r_bnode[i])
		);
	end

	// next state and result load
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_CMP;
			ST_CMP:  state_d = ST_UPD;
			ST_UPD:  state_d = ST_SCAN;
			ST_SCAN: if (scan_q == '0) state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// valid slot count after the update
	always_comb begin
		count_d = count_q;
		if (do_push) begin
			count_d = count_q + CW'(1);
		end else if (do_remove) begin
			count_d = count_q - CW'(1);
		end
	end

	// count, scan counter and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			scan_q    <= '0;
			dropped_q <= 1'b0;
		end else if (state_q == ST_UPD) begin
			count_q   <= count_d;
			scan_q    <= count_d;
			dropped_q <= (op_q == OP_UPSERT) && !any && full;
		end else if (state_q == ST_SCAN && scan_q != '0) begin
			scan_q <= scan_q - CW'(1);
		end
	end

	// command capture and registered match vector
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			node_q <= s_tdata[NODE_BITS-1:0];
			pred_q <= s_tdata[2*NODE_BITS-1:NODE_BITS];
			dist_q <= s_tdata[IN_W-1:2*NODE_BITS];
		end
		if (state_q == ST_CMP) begin
			match_q <= eqv;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= OUT_PW'({dropped_q, !c_valid[0], r_bnode[0], r_edge[0],
				r_fpred[0], r_fdist[0], r_found[0]});
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: rtl/core/sfpt_checker.sv
// ----------------------------------------------------------------------------
// sfpt_checker: port-level checks for the frontier table
// Watches both streams and the consistency of result fields.
// ----------------------------------------------------------------------------
module sfpt_checker #(
	parameter int NODE_BITS = 16,
	parameter int DIST_BITS = 32,
	parameter int OUT_PW    = 72
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_PW-1:0] m_tdata
);

	localparam int B_FOUND = 0;
	localparam int B_MIN   = 2 * NODE_BITS + DIST_BITS + 2 - NODE_BITS;
	localparam int B_EMPTY = 2 * NODE_BITS + DIST_BITS + 2;
	localparam int B_DROP  = B_EMPTY + 1;

	logic [NODE_BITS-1:0] min_node;
	assign min_node = m_tdata[B_MIN +: NODE_BITS];

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one command in work: busy right after an accepted transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while one is in work");

	// a new result appears only after a busy cycle
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a command in work");

	// empty table reports no node and no minimum
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[B_EMPTY] |-> !m_tdata[B_FOUND] && (min_node == '1))
		else $error("empty table result inconsistent");

	// a dropped insert leaves the node absent
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[B_DROP] |-> !m_tdata[B_FOUND] && !m_tdata[B_EMPTY])
		else $error("dropped insert reported as present");

endmodule

bind shortest_path_frontier_table_unit sfpt_checker #(
	.NODE_BITS (NODE_BITS),
	.DIST_BITS (DIST_BITS),
	.OUT_PW    (OUT_PW)
) u_sfpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/shortest_path_frontier_table_unit_tb.sv
// ----------------------------------------------------------------------------
// shortest_path_frontier_table_unit_tb: self-checking bench for the frontier table
// Sends a short table of directed commands and then a few hundred random ones
// on the s_ stream. Random commands come in phases that fill, churn and drain
// the table. An in-bench model of the slot chain predicts every result
// transaction. Both sides idle at random, and every result is compared field
// by field.
// ----------------------------------------------------------------------------
module shortest_path_frontier_table_unit_tb;
	import sfpt_pkg::*;

	localparam int ENTRIES      = ENTRIES_DEF;
	localparam int NODE_BITS    = NODE_BITS_DEF;
	localparam int DIST_BITS    = DIST_BITS_DEF;
	localparam int IN_W         = 2 * NODE_BITS + DIST_BITS;
	localparam int IN_PW        = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W        = 2 * NODE_BITS + DIST_BITS + 4;
	localparam int OUT_PW       = ((OUT_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 400;
	localparam int POOL_SIZE    = 72;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = ENTRIES + 16;
	localparam int DIRECTED_N   = 17;

	// spare operation code, handled as a query
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [NODE_BITS-1:0] NO_NODE  = '1;
	localparam logic [DIST_BITS-1:0] FAR_DIST = '1;

	// command fields as packed on s_tdata (node in the lowest bits)
	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		logic [NODE_BITS-1:0] predecessor;
		logic [NODE_BITS-1:0] node;
	} command_t;

	// result fields as packed on m_tdata (node_found in bit 0)
	typedef struct packed {
		logic                 insert_dropped;
		logic                 table_empty;
		logic [NODE_BITS-1:0] min_node;
		logic                 edge_found;
		logic [NODE_BITS-1:0] node_predecessor;
		logic [DIST_BITS-1:0] node_distance;
		logic                 node_found;
	} lookup_t;

	// one directed row; known holds the result when typed is set
	typedef struct packed {
		logic [1:0]           op;
		logic [NODE_BITS-1:0] node;
		logic [NODE_BITS-1:0] predecessor;
		logic [DIST_BITS-1:0] distance;
		logic                 typed;
		lookup_t              known;
	} dir_row_t;

	typedef enum int {
		MIX_FILL,
		MIX_BALANCED,
		MIX_DRAIN
	} mix_t;

	localparam lookup_t EMPTY_LOOKUP = '{1'b0, 1'b1, NO_NODE, 1'b0, NO_NODE, FAR_DIST, 1'b0};

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	// node, predecessor, distance
	logic [IN_PW-1:0]  s_tdata;
	// operation
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	// node_found, node_distance, node_predecessor, edge_found, min_node,
	// table_empty, insert_dropped
	logic [OUT_PW-1:0] m_tdata;

	// model of the slot chain, newest entry in slot 0
	logic [NODE_BITS-1:0] open_node [ENTRIES];
	logic [NODE_BITS-1:0] open_pred [ENTRIES];
	logic [DIST_BITS-1:0] open_dist [ENTRIES];
	int                   open_count;

	lookup_t  pending_lookups [$];
	dir_row_t directed_rows [DIRECTED_N];

	int errors;
	int items_sent;
	int results_seen;
	int drops_seen;
	int peak_count;
	int idle_cycles;
	int send_calm;
	int recv_calm;

	shortest_path_frontier_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock, period 12
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// slot holding a node, or -1
	function automatic int slot_of(logic [NODE_BITS-1:0] node);
		for (int i = 0; i < open_count; i++)
			if (open_node[i] == node)
				return i;
		return -1;
	endfunction

	// apply one command to the model and work out its result
	function automatic lookup_t apply_command(logic [1:0] op, command_t cmd);
		lookup_t r;
		int      pos;
		int      best;
		r = '0;
		pos = slot_of(cmd.node);
		if (op == OP_UPSERT) begin
			if (pos >= 0) begin
				open_dist[pos] = cmd.distance;
				open_pred[pos] = cmd.predecessor;
			end else if (open_count == ENTRIES) begin
				r.insert_dropped = 1'b1;
			end else begin
				// new node goes in front, the rest move back
				for (int i = open_count; i > 0; i--) begin
					open_node[i] = open_node[i-1];
					open_pred[i] = open_pred[i-1];
					open_dist[i] = open_dist[i-1];
				end
				open_node[0] = cmd.node;
				open_pred[0] = cmd.predecessor;
				open_dist[0] = cmd.distance;
				open_count++;
			end
		end else if (op == OP_REMOVE && pos >= 0) begin
			// close the gap
			for (int i = pos; i + 1 < open_count; i++) begin
				open_node[i] = open_node[i+1];
				open_pred[i] = open_pred[i+1];
				open_dist[i] = open_dist[i+1];
			end
			open_count--;
		end

		// lookup, edge and minimum after the operation; strict less keeps the newest on ties
		pos = slot_of(cmd.node);
		best = -1;
		for (int i = 0; i < open_count; i++) begin
			if (open_node[i] == cmd.node && open_pred[i] == cmd.predecessor)
				r.edge_found = 1'b1;
			if (best < 0 || open_dist[i] < open_dist[best])
				best = i;
		end
		if (pos >= 0) begin
			r.node_found       = 1'b1;
			r.node_distance    = open_dist[pos];
			r.node_predecessor = open_pred[pos];
		end else begin
			r.node_distance    = FAR_DIST;
			r.node_predecessor = NO_NODE;
		end
		if (best >= 0)
			r.min_node = open_node[best];
		else
			r.min_node = NO_NODE;
		r.table_empty = (open_count == 0);
		return r;
	endfunction

	// random wait per transaction, with stretches of no idling
	function automatic int pick_delay(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(10, 30);
		return $urandom_range(0, 11);
	endfunction

	// drive one command and record its expected result on acceptance
	task automatic send_command(input logic [1:0] op, input command_t cmd,
			input logic typed, input lookup_t known);
		int      gap;
		lookup_t predicted;
		gap = pick_delay(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= op;
		s_tdata  <= IN_PW'(cmd);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = apply_command(op, cmd);
		pending_lookups.push_back(typed ? known : predicted);
		if (predicted.insert_dropped)
			drops_seen++;
		if (open_count > peak_count)
			peak_count = open_count;
		items_sent++;
		@(negedge clk);
	endtask

	// result side ready with random stalls
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = pick_delay(recv_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		lookup_t got;
		lookup_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[OUT_W-1:0];
			results_seen++;
			if (pending_lookups.size() == 0) begin
				$error("result transaction with no command waiting");
				errors++;
			end else begin
				want = pending_lookups.pop_front();
				if (got.node_found !== want.node_found) begin
					$error("node_found: expected %0d, got %0d", want.node_found, got.node_found);
					errors++;
				end
				if (got.node_distance !== want.node_distance) begin
					$error("node_distance: expected %h, got %h",
						want.node_distance, got.node_distance);
					errors++;
				end
				if (got.node_predecessor !== want.node_predecessor) begin
					$error("node_predecessor: expected %h, got %h",
						want.node_predecessor, got.node_predecessor);
					errors++;
				end
				if (got.edge_found !== want.edge_found) begin
					$error("edge_found: expected %0d, got %0d", want.edge_found, got.edge_found);
					errors++;
				end
				if (got.min_node !== want.min_node) begin
					$error("min_node: expected %h, got %h", want.min_node, got.min_node);
					errors++;
				end
				if (got.table_empty !== want.table_empty) begin
					$error("table_empty: expected %0d, got %0d",
						want.table_empty, got.table_empty);
					errors++;
				end
				if (got.insert_dropped !== want.insert_dropped) begin
					$error("insert_dropped: expected %0d, got %0d",
						want.insert_dropped, got.insert_dropped);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus
	initial begin
		logic [NODE_BITS-1:0] pool [POOL_SIZE];
		command_t             cmd;
		logic [1:0]           op;
		mix_t                 mix;
		int                   fill_ptr;
		int                   pick;
		int                   slot;

		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_QUERY;
		arst_n      = 1'b0;
		errors      = 0;
		items_sent  = 0;
		results_seen = 0;
		drops_seen  = 0;
		peak_count  = 0;
		send_calm   = 0;
		recv_calm   = 0;
		open_count  = 0;
		fill_ptr    = 0;
		mix         = MIX_FILL;

		// op, node, predecessor, distance, typed, known result
		directed_rows = '{
			// query and remove on the empty table
			'{OP_QUERY,  16'h0000, 16'hFFFF, 32'h0000_0000, 1'b1, EMPTY_LOOKUP},
			'{OP_REMOVE, 16'h0005, 16'h0000, 32'h0000_0000, 1'b1, EMPTY_LOOKUP},
			// extremes of node, predecessor and distance
			'{OP_UPSERT, 16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
				'{1'b0, 1'b0, 16'hFFFE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1}},
			'{OP_UPSERT, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1,
				'{1'b0, 1'b0, 16'h0000, 1'b1, 16'h0000, 32'h0000_0000, 1'b1}},
			// update in place, then an edge miss on the old predecessor
			'{OP_UPSERT, 16'h0000, 16'h0007, 32'h0001_0000, 1'b0, '0},
			'{OP_QUERY,  16'h0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
			// equal distances, newest takes the minimum
			'{OP_UPSERT, 16'h0003, 16'h0001, 32'h0001_0000, 1'b0, '0},
			// spare code behaves as a query
			'{OP_SPARE,  16'h0003, 16'h0001, 32'hFFFF_FFFF, 1'b0, '0},
			// all-ones node stored like any other
			'{OP_UPSERT, 16'hFFFF, 16'h0002, 32'hFFFF_FFFF, 1'b0, '0},
			'{OP_QUERY,  16'hFFFF, 16'h0002, 32'h0000_0000, 1'b0, '0},
			// remove from the middle, then remove an absent node
			'{OP_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
			'{OP_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
			'{OP_REMOVE, 16'h0003, 16'h0001, 32'h0000_0000, 1'b0, '0},
			'{OP_REMOVE, 16'hFFFF, 16'h0000, 32'h0000_0000, 1'b0, '0},
			// last entry removed, table empty again
			'{OP_REMOVE, 16'hFFFE, 16'h0000, 32'h0000_0000, 1'b1, EMPTY_LOOKUP},
			'{OP_UPSERT, 16'h1234, 16'hABCD, 32'h0000_8000, 1'b0, '0},
			'{OP_QUERY,  16'hAAAA, 16'h5555, 32'h5555_AAAA, 1'b0, '0}
		};

		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = NODE_BITS'($urandom_range(0, 65534));

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_rows[r]) begin
			cmd.node        = directed_rows[r].node;
			cmd.predecessor = directed_rows[r].predecessor;
			cmd.distance    = directed_rows[r].distance;
			send_command(directed_rows[r].op, cmd, directed_rows[r].typed,
				directed_rows[r].known);
		end

		// random phases: fill first, then random phases of fill, churn and drain
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				mix = (n < 120) ? MIX_FILL : mix_t'($urandom_range(0, 2));

			// operation weights per phase
			pick = $urandom_range(0, 99);
			case (mix)
				MIX_FILL: begin
					op = (pick < 85) ? OP_UPSERT : (pick < 93) ? OP_REMOVE :
						(pick < 98) ? OP_QUERY : OP_SPARE;
				end
				MIX_BALANCED: begin
					op = (pick < 45) ? OP_UPSERT : (pick < 80) ? OP_REMOVE :
						(pick < 97) ? OP_QUERY : OP_SPARE;
				end
				default: begin
					op = (pick < 20) ? OP_UPSERT : (pick < 75) ? OP_REMOVE :
						(pick < 97) ? OP_QUERY : OP_SPARE;
				end
			endcase

			// node: walk the pool while filling, otherwise mostly pool hits
			if (mix == MIX_FILL && op == OP_UPSERT && $urandom_range(0, 9) < 7) begin
				cmd.node = pool[fill_ptr % POOL_SIZE];
				fill_ptr++;
			end else if ($urandom_range(0, 19) == 0) begin
				cmd.node = NODE_BITS'($urandom_range(0, 65534));
			end else begin
				cmd.node = pool[$urandom_range(0, POOL_SIZE - 1)];
			end

			// predecessor: often the stored one so edge queries hit
			slot = slot_of(cmd.node);
			if (op != OP_UPSERT && slot >= 0 && $urandom_range(0, 1) == 1) begin
				cmd.predecessor = open_pred[slot];
			end else begin
				case ($urandom_range(0, 3))
					0:       cmd.predecessor = NO_NODE;
					1:       cmd.predecessor = NODE_BITS'($urandom_range(0, 7));
					default: cmd.predecessor = NODE_BITS'($urandom);
				endcase
			end

			// distance: extremes, coarse values for ties, full range
			case ($urandom_range(0, 7))
				0:       cmd.distance = '0;
				1:       cmd.distance = FAR_DIST;
				2, 3:    cmd.distance = {16'($urandom_range(0, 15)), 16'h0000};
				default: cmd.distance = $urandom;
			endcase

			send_command(op, cmd, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// wait for the last results, then let the chain settle
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d commands, checked %0d results", items_sent, results_seen);
		$display("peak occupancy %0d of %0d slots, %0d inserts dropped on a full table",
			peak_count, ENTRIES, drops_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
